// File: hdl/spq_pkg.sv
// Shared types, codes and sizes for the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Queue capacity and derived count width
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  // Input item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  prio;
  } cell_cmd_t;

  typedef struct packed {
    logic                      valid;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  prio;
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/spq_cell.sv
// One slot of the sorted row: holds an entry and trades it with its neighbors.
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spq_pkg::cell_cmd_t cmd,
  input  wire spq_pkg::entry_t    left_entry,   // neighbor toward the front
  input  wire logic               left_behind,  // new item lands behind the left neighbor
  input  wire spq_pkg::entry_t    right_entry,  // neighbor toward the back
  output spq_pkg::entry_t         entry,
  output logic                    behind        // new item lands behind this cell
);

  spq_pkg::entry_t entry_next;

  // New item stays behind every stored entry of equal or higher priority
  assign behind = entry.valid && !($signed(cmd.prio) > $signed(entry.prio));

  // Next contents: keep, take the new item, or shift from a neighbor
  always_comb begin
    entry_next = entry;
    case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (!behind) begin
          if (left_behind) begin
            entry_next.valid = 1'b1;
            entry_next.value = cmd.value;
            entry_next.prio  = cmd.prio;
          end else begin
            entry_next = left_entry;
          end
        end
      end
      spq_pkg::OP_REMOVE: begin
        entry_next = right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // Valid bit resets; payload does not
  always_ff @(posedge clk) begin
    entry.value <= entry_next.value;
    entry.prio  <= entry_next.prio;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sorted_priority_queue_unit.sv
// Sorted priority queue: a row of cells kept in descending priority order.
//
// Input channel s_axis: tuser carries the kind (0 insert, 1 remove), tdata
// carries the data word and its priority. Output channel m_axis: one result
// item per input item, tuser carries the status (done, full, empty), tdata
// carries the removed word, its priority and the occupancy after the item.
// For each item, all cells compare the new priority with their own in
// parallel and shift or hold in the same clock edge, so an item is accepted
// in every cycle while the output register is free or being read, and its
// result appears in the output register on the next cycle. The single
// output register sets the pace: while a result waits unread, no new item
// is accepted, and an item is taken in the same cycle the waiting result leaves.
// Reset clears all valid bits and the entry count; the queue is empty and
// ready for items in the first cycle after reset. Equal priorities leave in
// arrival order. An insert into a full queue and a remove from an empty one
// leave the contents unchanged and report their status.
`default_nettype none

module sorted_priority_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // item_value[31:0], item_priority[63:32]
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // removed_value[31:0], removed_priority[63:32],
                                           // occupancy[68:64], zero[71:69]
  output logic [1:0]       m_axis_tuser    // status
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int CNT_W = spq_pkg::CNT_W;

  spq_pkg::entry_t    cells [DEPTH];
  logic [DEPTH-1:0]   behind_vec;
  logic [DEPTH-1:0]   valid_vec;
  spq_pkg::cell_cmd_t cmd;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               in_accept;
  logic               is_full;
  logic               is_empty;

  // Output register
  logic                        out_valid;
  spq_pkg::status_t            out_status;
  logic signed [31:0]          out_value;
  logic signed [31:0]          out_priority;
  logic [spq_pkg::OCC_W-1:0]   out_occ;
  spq_pkg::status_t            status_next;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign is_full       = (count == CNT_W'(DEPTH));
  assign is_empty      = (count == '0);

  // Decide the cell operation and status for the incoming item
  always_comb begin
    cmd.op      = spq_pkg::OP_HOLD;
    cmd.value   = s_axis_tdata[31:0];
    cmd.prio    = s_axis_tdata[63:32];
    status_next = spq_pkg::ST_DONE;
    count_next  = count;
    if (s_axis_tuser == spq_pkg::KIND_INSERT) begin
      if (is_full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        cmd.op     = in_accept ? spq_pkg::OP_INSERT : spq_pkg::OP_HOLD;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        cmd.op     = in_accept ? spq_pkg::OP_REMOVE : spq_pkg::OP_HOLD;
        count_next = count - CNT_W'(1);
      end
    end
  end

  // Row of cells, front entry in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_behind;

    if (i == 0) begin : g_front
      assign left_entry  = '{valid: 1'b1, value: '0, prio: '0};
      assign left_behind = 1'b1;
    end else begin : g_mid
      assign left_entry  = cells[i-1];
      assign left_behind = behind_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_entry = '{valid: 1'b0, value: '0, prio: '0};
    end else begin : g_inner
      assign right_entry = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_entry  (left_entry),
      .left_behind (left_behind),
      .right_entry (right_entry),
      .entry       (cells[i]),
      .behind      (behind_vec[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_accept) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_status <= status_next;
      out_occ    <= spq_pkg::OCC_W'(count_next);
      if (s_axis_tuser == spq_pkg::KIND_REMOVE && !is_empty) begin
        out_value    <= cells[0].value;
        out_priority <= cells[0].prio;
      end else begin
        out_value    <= '0;
        out_priority <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {3'b000, out_occ, out_priority, out_value};

  // The number of stored entries matches the count
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("valid bits disagree with entry count");

  // Front two entries stay in descending priority order
  a_front_order: assert property (@(posedge clk) disable iff (rst)
    cells[1].valid |->
    (cells[0].valid && $signed(cells[0].prio) >= $signed(cells[1].prio)))
    else $error("front entries out of priority order");

  // A successful remove reports the entry that was at the front
  a_remove_front: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tuser == spq_pkg::KIND_REMOVE && !is_empty) |=>
    (out_priority == $past(cells[0].prio) && out_value == $past(cells[0].value)))
    else $error("remove did not return the front entry");

  // A refused insert leaves the count unchanged
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tuser == spq_pkg::KIND_INSERT && is_full) |=>
    (count == $past(count) && out_status == spq_pkg::ST_FULL))
    else $error("refused insert changed the queue");

endmodule

`default_nettype wire
